FILE: design/banked_memory_map_decoder_unit_assert.svh
// assertion macros for the memory map decoder
`ifndef BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH
`define BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BMMD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmmd check failed");
`define BMMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmmd check failed");
`else
`define BMMD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BMMD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: design/bmmd_pkg.sv
package bmmd_pkg;

   localparam int BANK_BYTES     = 4096;
   localparam int BANK_COUNT_DEF = 8;
   localparam int OFFSET_BITS    = $clog2(BANK_BYTES);
   localparam int HRAM_DEPTH     = 127;
   localparam int HRAM_BITS      = 7;

   localparam logic [15:0] ADDR_CART_END   = 16'h7fff;
   localparam logic [15:0] ADDR_XRAM_BEGIN = 16'ha000;
   localparam logic [15:0] ADDR_XRAM_END   = 16'hbfff;
   localparam logic [15:0] ADDR_WRAM_BEGIN = 16'hc000;
   localparam logic [15:0] ADDR_ECHO_END   = 16'hfdff;
   localparam logic [15:0] ADDR_JOYPAD     = 16'hff00;
   localparam logic [15:0] ADDR_SERIAL_LO  = 16'hff01;
   localparam logic [15:0] ADDR_SERIAL_HI  = 16'hff02;
   localparam logic [15:0] ADDR_TIMER_LO   = 16'hff04;
   localparam logic [15:0] ADDR_TIMER_HI   = 16'hff07;
   localparam logic [15:0] ADDR_IRQ_FLAGS  = 16'hff0f;
   localparam logic [15:0] ADDR_SPEED      = 16'hff4d;
   localparam logic [15:0] ADDR_HDMA_LO    = 16'hff51;
   localparam logic [15:0] ADDR_HDMA_HI    = 16'hff55;
   localparam logic [15:0] ADDR_BANK       = 16'hff70;
   localparam logic [15:0] ADDR_HRAM_BEGIN = 16'hff80;
   localparam logic [15:0] ADDR_IRQ_ENABLE = 16'hffff;

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_SWITCH = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ROUTE_LOCAL  = 3'd0,
      ROUTE_CART   = 3'd1,
      ROUTE_JOYPAD = 3'd2,
      ROUTE_SERIAL = 3'd3,
      ROUTE_TIMER  = 3'd4,
      ROUTE_HDMA   = 3'd5
   } route_type;

   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_REG  = 2'd1,
      SRC_WRAM = 2'd2,
      SRC_HRAM = 2'd3
   } src_type;

   typedef struct packed {
      route_type route;
      logic      wram;
      logic      wram_fixed;
      logic      hram;
      logic      irq_flags;
      logic      irq_enables;
      logic      speed;
      logic      bank;
   } decode_type;

   typedef struct packed {
      logic [2:0] bank;
      logic       armed;
      logic       speed;
   } status_type;

   // bank select reduced below the bank count
   function automatic logic [2:0] bank_mod(input logic [2:0] bank, input logic [3:0] count);
      logic [3:0] b;
      b = {1'b0, bank};
      for (int i = 0; i < 4; i++) begin
         if (b >= count) begin
            b = b - count;
         end
      end
      return b[2:0];
   endfunction

endpackage

FILE: design/bmmd_ram.sv
module bmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/bmmd_decode.sv
module bmmd_decode (
   input  logic [15:0]         address,
   output bmmd_pkg::decode_type dec
);

   always_comb begin
      dec = '0;
      dec.route = bmmd_pkg::ROUTE_LOCAL;
      if (address <= bmmd_pkg::ADDR_CART_END ||
          (address >= bmmd_pkg::ADDR_XRAM_BEGIN && address <= bmmd_pkg::ADDR_XRAM_END)) begin
         dec.route = bmmd_pkg::ROUTE_CART;
      end else if (address == bmmd_pkg::ADDR_JOYPAD) begin
         dec.route = bmmd_pkg::ROUTE_JOYPAD;
      end else if (address == bmmd_pkg::ADDR_SERIAL_LO || address == bmmd_pkg::ADDR_SERIAL_HI) begin
         dec.route = bmmd_pkg::ROUTE_SERIAL;
      end else if (address >= bmmd_pkg::ADDR_TIMER_LO && address <= bmmd_pkg::ADDR_TIMER_HI) begin
         dec.route = bmmd_pkg::ROUTE_TIMER;
      end else if (address >= bmmd_pkg::ADDR_HDMA_LO && address <= bmmd_pkg::ADDR_HDMA_HI) begin
         dec.route = bmmd_pkg::ROUTE_HDMA;
      end

      // bank 0 in c000-cfff and its echo e000-efff
      dec.wram        = address >= bmmd_pkg::ADDR_WRAM_BEGIN && address <= bmmd_pkg::ADDR_ECHO_END;
      dec.wram_fixed  = !address[12];
      dec.hram        = address >= bmmd_pkg::ADDR_HRAM_BEGIN &&
                        address != bmmd_pkg::ADDR_IRQ_ENABLE;
      dec.irq_flags   = address == bmmd_pkg::ADDR_IRQ_FLAGS;
      dec.irq_enables = address == bmmd_pkg::ADDR_IRQ_ENABLE;
      dec.speed       = address == bmmd_pkg::ADDR_SPEED;
      dec.bank        = address == bmmd_pkg::ADDR_BANK;
   end

endmodule

FILE: design/bmmd_regs.sv
module bmmd_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [1:0]            mode,
   input  bmmd_pkg::decode_type  dec,
   input  logic [7:0]            write_data,
   output bmmd_pkg::status_type  status,
   output logic [7:0]            reg_rdata,
   output logic                  speed_next
);

   logic [2:0] bank_ff, bank_in;
   logic [7:0] flags_ff, flags_in;
   logic [7:0] enables_ff, enables_in;
   logic       speed_ff, speed_in;
   logic       armed_ff, armed_in;
   logic       write_en;
   logic       switch_en;

   assign write_en  = advance && mode == bmmd_pkg::MODE_WRITE &&
                      dec.route == bmmd_pkg::ROUTE_LOCAL;
   assign switch_en = advance && mode == bmmd_pkg::MODE_SWITCH;

   always_comb begin
      bank_in    = bank_ff;
      flags_in   = flags_ff;
      enables_in = enables_ff;
      speed_in   = speed_ff;
      armed_in   = armed_ff;
      if (write_en) begin
         if (dec.irq_flags) begin
            flags_in = write_data;
         end
         if (dec.irq_enables) begin
            enables_in = write_data;
         end
         if (dec.speed) begin
            armed_in = write_data[0];
         end
         if (dec.bank) begin
            bank_in = (write_data[2:0] == 3'd0) ? 3'd1 : write_data[2:0];
         end
      end
      if (switch_en) begin
         speed_in = speed_ff ^ armed_ff;
         armed_in = 1'b0;
      end
   end

   always_comb begin
      reg_rdata = 8'd0;
      if (dec.irq_flags) begin
         reg_rdata = flags_ff;
      end else if (dec.irq_enables) begin
         reg_rdata = enables_ff;
      end else if (dec.speed) begin
         reg_rdata = {speed_ff, 6'd0, armed_ff};
      end else if (dec.bank) begin
         reg_rdata = {5'd0, bank_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff    <= 3'd1;
         flags_ff   <= 8'd0;
         enables_ff <= 8'd0;
         speed_ff   <= 1'b0;
         armed_ff   <= 1'b0;
      end else begin
         bank_ff    <= bank_in;
         flags_ff   <= flags_in;
         enables_ff <= enables_in;
         speed_ff   <= speed_in;
         armed_ff   <= armed_in;
      end
   end

   assign status.bank  = bank_ff;
   assign status.armed = armed_ff;
   assign status.speed = speed_ff;
   assign speed_next   = speed_in;

endmodule

FILE: design/banked_memory_map_decoder_unit.sv
// memory map decoder for a handheld console cpu bus
// req channel: one bus access per transaction; req_tuser holds the mode
//   (read, write or speed switch), req_tdata the address and write byte
// rsp channel: one transaction per access with the route code, the byte
//   read when the access is handled locally, and the speed mode after it
// an input register feeds the decoder, the work ram and high ram ports and
//   the control registers; a result register and the output register of each
//   ram hold the answer
// throughput is one transaction per cycle while the rsp side does not stall,
//   set by the single port of each ram, which does one read or one write per access
// while the rsp side stalls the result register holds and the input register
//   takes one more transaction, after which req_tready drops
// reset clears the pipeline valids, selects bank 1 and clears the interrupt,
//   speed and armed registers; ram contents are undefined until written
module banked_memory_map_decoder_unit #(
   parameter int BANK_COUNT = bmmd_pkg::BANK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address[15:0], write_data[23:16], zero
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // route[2:0], read_data[10:3], double_speed[11], zero
);

   localparam int WRAM_DEPTH = bmmd_pkg::BANK_BYTES * BANK_COUNT;
   localparam int WRAM_BITS  = $clog2(WRAM_DEPTH);
   localparam int BANK_BITS  = $clog2(BANK_COUNT);

   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           mode_ff;
   logic [15:0]          addr_ff;
   logic [7:0]           wdata_ff;
   logic                 out_valid_ff, out_valid_in;
   bmmd_pkg::route_type  route_ff;
   bmmd_pkg::src_type    src_ff, src_in;
   logic [7:0]           small_ff;
   logic                 double_ff;

   logic                 req_accept;
   logic                 advance;
   logic                 is_read;
   logic                 is_write;
   bmmd_pkg::decode_type dec;
   bmmd_pkg::status_type status;
   logic [7:0]           reg_rdata;
   logic                 speed_next;
   bmmd_pkg::route_type  route_in;
   logic [2:0]           bank_sel;
   logic [WRAM_BITS-1:0] wram_addr;
   logic [7:0]           wram_rdata;
   logic [7:0]           hram_rdata;
   logic [7:0]           read_data;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign is_read  = mode_ff == bmmd_pkg::MODE_READ;
   assign is_write = mode_ff == bmmd_pkg::MODE_WRITE;

   bmmd_decode u_decode (
      .address (addr_ff),
      .dec     (dec)
   );

   bmmd_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .mode       (mode_ff),
      .dec        (dec),
      .write_data (wdata_ff),
      .status     (status),
      .reg_rdata  (reg_rdata),
      .speed_next (speed_next)
   );

   assign bank_sel  = dec.wram_fixed ? 3'd0 : bmmd_pkg::bank_mod(status.bank, 4'(BANK_COUNT));
   assign wram_addr = {bank_sel[BANK_BITS-1:0], addr_ff[bmmd_pkg::OFFSET_BITS-1:0]};

   bmmd_ram #(
      .WIDTH (8),
      .DEPTH (WRAM_DEPTH)
   ) u_wram (
      .clock (clock),
      .en    (advance && dec.wram && (is_read || is_write)),
      .we    (is_write),
      .addr  (wram_addr),
      .wdata (wdata_ff),
      .rdata (wram_rdata)
   );

   bmmd_ram #(
      .WIDTH (8),
      .DEPTH (bmmd_pkg::HRAM_DEPTH)
   ) u_hram (
      .clock (clock),
      .en    (advance && dec.hram && (is_read || is_write)),
      .we    (is_write),
      .addr  (addr_ff[bmmd_pkg::HRAM_BITS-1:0]),
      .wdata (wdata_ff),
      .rdata (hram_rdata)
   );

   always_comb begin
      route_in = (is_read || is_write) ? dec.route : bmmd_pkg::ROUTE_LOCAL;
      src_in   = bmmd_pkg::SRC_ZERO;
      if (is_read && dec.route == bmmd_pkg::ROUTE_LOCAL) begin
         if (dec.wram) begin
            src_in = bmmd_pkg::SRC_WRAM;
         end else if (dec.hram) begin
            src_in = bmmd_pkg::SRC_HRAM;
         end else if (dec.irq_flags || dec.irq_enables || dec.speed || dec.bank) begin
            src_in = bmmd_pkg::SRC_REG;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_tuser;
         addr_ff  <= req_tdata[15:0];
         wdata_ff <= req_tdata[23:16];
      end
      if (advance) begin
         route_ff  <= route_in;
         src_ff    <= src_in;
         small_ff  <= reg_rdata;
         double_ff <= speed_next;
      end
   end

   always_comb begin
      case (src_ff)
         bmmd_pkg::SRC_REG:  read_data = small_ff;
         bmmd_pkg::SRC_WRAM: read_data = wram_rdata;
         bmmd_pkg::SRC_HRAM: read_data = hram_rdata;
         default:            read_data = 8'd0;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, double_ff, read_data, route_ff};

`include "banked_memory_map_decoder_unit_assert.svh"

   `BMMD_ASSERT_SAME(a_routed_no_data, clock, reset, out_valid_ff && route_ff != bmmd_pkg::ROUTE_LOCAL, read_data == 8'd0)
   `BMMD_ASSERT_NEXT(a_switch_disarms, clock, reset, advance && mode_ff == bmmd_pkg::MODE_SWITCH, !status.armed)
   `BMMD_ASSERT_SAME(a_bank_nonzero, clock, reset, 1'b1, status.bank != 3'd0)
   `BMMD_ASSERT_SAME(a_stall_full, clock, reset, !req_tready, in_valid_ff && out_valid_ff)

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int BANKS       = bmmd_pkg::BANK_COUNT_DEF;
   localparam int WRAM_BYTES  = bmmd_pkg::BANK_BYTES * BANKS;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      bmmd_pkg::route_type route;
      logic [7:0]          read_data;
      logic                double_speed;
   } access_answer_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // address[15:0], write_data[23:16], zero
   logic [1:0]  req_tuser  = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // route[2:0], read_data[10:3], double_speed[11], zero

   // bus state as the decoder should hold it
   logic [7:0] wram_image [0:WRAM_BYTES-1];
   bit         wram_known [0:WRAM_BYTES-1];
   logic [7:0] hram_image [0:bmmd_pkg::HRAM_DEPTH-1];
   bit         hram_known [0:bmmd_pkg::HRAM_DEPTH-1];
   int         written_wram [$];
   int         written_hram [$];
   logic [2:0] bank_now      = 3'd1;
   logic [7:0] irq_flag_now  = 8'h00;
   logic [7:0] irq_enable_now = 8'h00;
   logic       speed_now     = 1'b0;
   logic       armed_now     = 1'b0;

   access_answer_type pending_answers [$];
   int errors      = 0;
   int idle_cycles = 0;
   int ready_hold  = 0;
   bit quiet_run   = 1'b0;

   banked_memory_map_decoder_unit #(.BANK_COUNT(BANKS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_run || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int wram_slot(logic [15:0] a);
      if (a < bmmd_pkg::ADDR_WRAM_BEGIN || a > bmmd_pkg::ADDR_ECHO_END) return -1;
      if (a < 16'hd000 || (a >= 16'he000 && a < 16'hf000)) return int'(a[11:0]);
      return int'(bank_now) % BANKS * bmmd_pkg::BANK_BYTES + int'(a[11:0]);
   endfunction

   function automatic bit in_hram(logic [15:0] a);
      return a >= bmmd_pkg::ADDR_HRAM_BEGIN && a < bmmd_pkg::ADDR_IRQ_ENABLE;
   endfunction

   function automatic bmmd_pkg::route_type route_for(logic [15:0] a);
      if (a <= bmmd_pkg::ADDR_CART_END ||
          (a >= bmmd_pkg::ADDR_XRAM_BEGIN && a <= bmmd_pkg::ADDR_XRAM_END))
         return bmmd_pkg::ROUTE_CART;
      if (a == bmmd_pkg::ADDR_JOYPAD) return bmmd_pkg::ROUTE_JOYPAD;
      if (a >= bmmd_pkg::ADDR_SERIAL_LO && a <= bmmd_pkg::ADDR_SERIAL_HI)
         return bmmd_pkg::ROUTE_SERIAL;
      if (a >= bmmd_pkg::ADDR_TIMER_LO && a <= bmmd_pkg::ADDR_TIMER_HI)
         return bmmd_pkg::ROUTE_TIMER;
      if (a >= bmmd_pkg::ADDR_HDMA_LO && a <= bmmd_pkg::ADDR_HDMA_HI)
         return bmmd_pkg::ROUTE_HDMA;
      return bmmd_pkg::ROUTE_LOCAL;
   endfunction

   // false when a read would land on a ram byte that was never written
   function automatic bit read_is_defined(logic [15:0] a);
      int slot;
      slot = wram_slot(a);
      if (route_for(a) != bmmd_pkg::ROUTE_LOCAL) return 1'b1;
      if (slot >= 0) return wram_known[slot];
      if (in_hram(a)) return hram_known[int'(a - bmmd_pkg::ADDR_HRAM_BEGIN)];
      return 1'b1;
   endfunction

   function automatic access_answer_type predict_access(bmmd_pkg::mode_type m,
                                                        logic [15:0] a, logic [7:0] d);
      access_answer_type ans;
      int slot;
      int hi;
      ans  = '0;
      slot = wram_slot(a);
      hi   = int'(a - bmmd_pkg::ADDR_HRAM_BEGIN);
      if (m == bmmd_pkg::MODE_SWITCH) begin
         if (armed_now) speed_now = ~speed_now;
         armed_now = 1'b0;
      end else begin
         ans.route = route_for(a);
         if (ans.route == bmmd_pkg::ROUTE_LOCAL && m == bmmd_pkg::MODE_READ) begin
            if (slot >= 0) ans.read_data = wram_image[slot];
            else if (a == bmmd_pkg::ADDR_IRQ_FLAGS) ans.read_data = irq_flag_now;
            else if (a == bmmd_pkg::ADDR_SPEED) ans.read_data = {speed_now, 6'b0, armed_now};
            else if (a == bmmd_pkg::ADDR_BANK) ans.read_data = {5'b0, bank_now};
            else if (in_hram(a)) ans.read_data = hram_image[hi];
            else if (a == bmmd_pkg::ADDR_IRQ_ENABLE) ans.read_data = irq_enable_now;
         end else if (ans.route == bmmd_pkg::ROUTE_LOCAL && m == bmmd_pkg::MODE_WRITE) begin
            if (slot >= 0) begin
               if (!wram_known[slot]) written_wram.push_back(slot);
               wram_known[slot] = 1'b1;
               wram_image[slot] = d;
            end else if (a == bmmd_pkg::ADDR_IRQ_FLAGS) begin
               irq_flag_now = d;
            end else if (a == bmmd_pkg::ADDR_SPEED) begin
               armed_now = d[0];
            end else if (a == bmmd_pkg::ADDR_BANK) begin
               bank_now = (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
            end else if (in_hram(a)) begin
               if (!hram_known[hi]) written_hram.push_back(hi);
               hram_known[hi] = 1'b1;
               hram_image[hi] = d;
            end else if (a == bmmd_pkg::ADDR_IRQ_ENABLE) begin
               irq_enable_now = d;
            end
         end
      end
      ans.double_speed = speed_now;
      return ans;
   endfunction

   // address of a byte already stored, seen through the current bank, or the bank register if none fits
   function automatic logic [15:0] pick_stored_address();
      int slot;
      int bank;
      logic [11:0] off;
      if (written_hram.size() != 0 && $urandom_range(0, 3) == 0)
         return bmmd_pkg::ADDR_HRAM_BEGIN +
                16'(written_hram[$urandom_range(0, written_hram.size() - 1)]);
      for (int tries = 0; tries < 4 && written_wram.size() != 0; tries++) begin
         slot = written_wram[$urandom_range(0, written_wram.size() - 1)];
         off  = slot[11:0];
         bank = slot / bmmd_pkg::BANK_BYTES;
         if (bank == 0) return {($urandom_range(0, 1) != 0) ? 4'hc : 4'he, off};
         if (bank == int'(bank_now) % BANKS) begin
            if (off < 12'he00 && $urandom_range(0, 1) != 0) return {4'hf, off};
            return {4'hd, off};
         end
      end
      return bmmd_pkg::ADDR_BANK;
   endfunction

   task automatic send_access(input bmmd_pkg::mode_type m, input logic [15:0] a,
                              input logic [7:0] d);
      int gap;
      gap = pick_gap();
      if (m == bmmd_pkg::MODE_READ && !read_is_defined(a)) m = bmmd_pkg::MODE_WRITE;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {8'h00, d, a};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(predict_access(m, a, d));
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic test_reset_state();
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_BANK, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_SPEED, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_IRQ_FLAGS, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_IRQ_ENABLE, 8'h00);
      send_access(bmmd_pkg::MODE_SWITCH, 16'h0000, 8'h00);
   endtask

   task automatic test_route_decode();
      send_access(bmmd_pkg::MODE_WRITE, 16'h0000, 8'hff);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_CART_END, 8'h00);
      send_access(bmmd_pkg::MODE_READ, 16'h9fff, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_XRAM_END, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_JOYPAD, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_SERIAL_HI, 8'h81);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_TIMER_LO, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_HDMA_HI, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, 16'hff46, 8'hc0);
      send_access(bmmd_pkg::MODE_READ, 16'hff46, 8'h00);
   endtask

   task automatic test_bank_select();
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_BANK, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_BANK, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_WRAM_BEGIN, 8'hff);
      send_access(bmmd_pkg::MODE_READ, 16'he000, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_BANK, 8'hff);
      send_access(bmmd_pkg::MODE_WRITE, 16'hd123, 8'h3c);
      send_access(bmmd_pkg::MODE_READ, 16'hf123, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_BANK, 8'h00);
   endtask

   task automatic test_speed_switch();
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_SPEED, 8'hff);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_SPEED, 8'h00);
      send_access(bmmd_pkg::MODE_SWITCH, 16'hffff, 8'hff);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_SPEED, 8'h00);
      send_access(bmmd_pkg::MODE_SWITCH, 16'h0000, 8'h00);
   endtask

   task automatic test_high_ram_and_irq();
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_HRAM_BEGIN, 8'hff);
      send_access(bmmd_pkg::MODE_WRITE, 16'hfffe, 8'h00);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_HRAM_BEGIN, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_IRQ_ENABLE, 8'ha5);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_IRQ_ENABLE, 8'h00);
      send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_IRQ_FLAGS, 8'h5a);
      send_access(bmmd_pkg::MODE_READ, bmmd_pkg::ADDR_IRQ_FLAGS, 8'h00);
   endtask

   task automatic issue_random_access();
      int kind;
      logic [15:0] a;
      logic [7:0] d;
      bmmd_pkg::mode_type rw;
      kind = $urandom_range(0, 99);
      d    = 8'($urandom_range(0, 255));
      rw   = bmmd_pkg::mode_type'($urandom_range(0, 1));
      if (kind < 25) begin
         send_access(bmmd_pkg::MODE_WRITE, 16'($urandom_range(16'hc000, 16'hfdff)), d);
      end else if (kind < 50) begin
         send_access(bmmd_pkg::MODE_READ, pick_stored_address(), d);
      end else if (kind < 58) begin
         send_access(rw, 16'($urandom_range(16'hff80, 16'hfffe)), d);
      end else if (kind < 62) begin
         send_access(rw, bmmd_pkg::ADDR_BANK, d);
      end else if (kind < 67) begin
         send_access(bmmd_pkg::MODE_WRITE, bmmd_pkg::ADDR_SPEED, d);
         send_access(bmmd_pkg::MODE_SWITCH, 16'($urandom()), 8'($urandom()));
      end else if (kind < 70) begin
         send_access(bmmd_pkg::mode_type'($urandom_range(0, 2)), bmmd_pkg::ADDR_SPEED, d);
      end else if (kind < 75) begin
         send_access(rw, ($urandom_range(0, 1) != 0) ? bmmd_pkg::ADDR_IRQ_FLAGS
                                                      : bmmd_pkg::ADDR_IRQ_ENABLE, d);
      end else if (kind < 85) begin
         case ($urandom_range(0, 5))
            0: a = 16'($urandom_range(0, 16'h7fff));
            1: a = 16'($urandom_range(16'ha000, 16'hbfff));
            2: a = bmmd_pkg::ADDR_JOYPAD;
            3: a = 16'($urandom_range(16'hff01, 16'hff02));
            4: a = 16'($urandom_range(16'hff04, 16'hff07));
            default: a = 16'($urandom_range(16'hff51, 16'hff55));
         endcase
         send_access(rw, a, d);
      end else if (kind < 90) begin
         send_access(rw, 16'($urandom_range(16'hfe00, 16'hff7f)), d);
      end else begin
         send_access(bmmd_pkg::mode_type'($urandom_range(0, 2)), 16'($urandom()), d);
      end
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) drain_responses();
         quiet_run = (i >= count / 2 && i < count / 2 + 150);
         issue_random_access();
      end
      quiet_run = 1'b0;
   endtask

   always @(posedge clock) begin
      if (quiet_run) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      access_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[2:0] !== want.route) begin
               $display("%0t route: expected %0d actual %0d", $time, want.route, rsp_tdata[2:0]);
               errors++;
            end
            if (rsp_tdata[10:3] !== want.read_data) begin
               $display("%0t read_data: expected %h actual %h", $time, want.read_data,
                        rsp_tdata[10:3]);
               errors++;
            end
            if (rsp_tdata[11] !== want.double_speed) begin
               $display("%0t double_speed: expected %0d actual %0d", $time,
                        want.double_speed, rsp_tdata[11]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("[banked_memory_map_decoder_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_route_decode();
      test_bank_select();
      test_speed_switch();
      test_high_ram_and_irq();
      test_random_traffic(1800);
      drain_responses();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("[banked_memory_map_decoder_unit] OK");
      end else begin
         $display("[banked_memory_map_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule
